/* src/smv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smv_pkg;

	// Default geometry and number format
	localparam int VectorDepth   = 1024;
	localparam int FractionBits  = 16;
	localparam int IndexWidth    = 10;
	localparam int ValueWidth    = 32;
	localparam int RowIndexWidth = 16;
	localparam int ModeWidth     = 3;
	localparam int OpWidth       = 2;

	// Item operation codes
	localparam logic [OpWidth-1:0] OP_LOAD    = 2'd0;
	localparam logic [OpWidth-1:0] OP_NONZERO = 2'd1;
	localparam logic [OpWidth-1:0] OP_EMPTY   = 2'd2;

	// Semiring selection; unlisted codes act as plus-times
	localparam logic [ModeWidth-1:0] MODE_PLUS_TIMES = 3'd0;
	localparam logic [ModeWidth-1:0] MODE_MIN_PLUS   = 3'd1;
	localparam logic [ModeWidth-1:0] MODE_MAX_TIMES  = 3'd2;
	localparam logic [ModeWidth-1:0] MODE_OR_AND     = 3'd3;
	localparam logic [ModeWidth-1:0] MODE_MAX_PLUS   = 3'd4;

	localparam logic signed [ValueWidth-1:0] FixMax = 32'sh7fff_ffff;
	localparam logic signed [ValueWidth-1:0] FixMin = 32'sh8000_0000;

	// Control that travels along the pipeline with each item
	typedef struct packed {
		logic               valid;
		logic [OpWidth-1:0] op;
		logic               last;
	} smv_ctrl_t;

	// Saturating signed add
	function automatic logic signed [ValueWidth-1:0] sat_add(
		input logic signed [ValueWidth-1:0] a,
		input logic signed [ValueWidth-1:0] b
	);
		logic signed [ValueWidth:0] s;
		s = {a[ValueWidth-1], a} + {b[ValueWidth-1], b};
		if (s[ValueWidth] != s[ValueWidth-1]) begin
			return s[ValueWidth] ? FixMin : FixMax;
		end
		return s[ValueWidth-1:0];
	endfunction

	// Additive identity of a semiring
	function automatic logic signed [ValueWidth-1:0] identity_of(
		input logic [ModeWidth-1:0] mode
	);
		logic signed [ValueWidth-1:0] r;
		unique case (mode)
			MODE_MIN_PLUS:  r = FixMax;
			MODE_MAX_TIMES: r = FixMin;
			MODE_MAX_PLUS:  r = FixMin;
			default:        r = '0;
		endcase
		return r;
	endfunction

	// Semiring addition; one is the fixed-point 1.0
	function automatic logic signed [ValueWidth-1:0] sr_add(
		input logic [ModeWidth-1:0]         mode,
		input logic signed [ValueWidth-1:0] a,
		input logic signed [ValueWidth-1:0] b,
		input logic signed [ValueWidth-1:0] one
	);
		logic signed [ValueWidth-1:0] r;
		unique case (mode)
			MODE_MIN_PLUS:  r = (a < b) ? a : b;
			MODE_MAX_TIMES: r = (a > b) ? a : b;
			MODE_MAX_PLUS:  r = (a > b) ? a : b;
			MODE_OR_AND:    r = (a != '0 || b != '0) ? one : '0;
			default:        r = sat_add(a, b);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/semiring_sparse_matvec_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Semiring sparse matrix-vector unit, y = A (x) x over a CSR item stream.
// Input items (s_axis) carry an operation in tuser: load a vector entry, a
// matrix nonzero, or an empty-row marker; tlast marks the last nonzero of a row.
// Load the vector first, then stream the nonzeros row by row. Each finished
// row leaves on m_axis with its semiring reduction and a wrapping row number.
// The semiring is chosen by the one configuration register, written through
// cfg_wr_en/cfg_wr_data; the user writes it only while no item is in flight, as the block does not enforce this.
// Throughput: one item per cycle while the output is not stalled. A row result
// reaches the output register through the vector store read, multiply, product
// select and accumulate steps after its closing item is accepted.
// The vector store is a single-port-write, registered-read memory; a load is
// written at acceptance, so a nonzero may read it in the very next cycle.
// Reset clears the pipeline, row counter and open-row flag, and selects
// plus-times; the vector store keeps no reset and must be loaded before use.
// When the receiver stalls, the pipeline keeps taking items until a row
// result would overwrite the waiting one; then s_axis_tready drops and all
// stages hold until the waiting result is taken.
module semiring_sparse_matvec_unit #(
	parameter int VECTOR_DEPTH  = smv_pkg::VectorDepth,
	parameter int FRACTION_BITS = smv_pkg::FractionBits
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input items
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [47:0]                       s_axis_tdata,  // index[9:0], value[41:10]
	input  wire logic [smv_pkg::OpWidth-1:0]       s_axis_tuser,  // operation[1:0]
	input  wire logic                              s_axis_tlast,  // row_last
	// Row results
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [47:0]                            m_axis_tdata,  // row_value[31:0], row_index[47:32]
	// Configuration
	input  wire logic                              cfg_wr_en,
	input  wire logic [smv_pkg::ModeWidth-1:0]     cfg_wr_data    // semiring_mode
);

	localparam int W  = smv_pkg::ValueWidth;
	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam logic signed [W-1:0] FixOne = W'(1) << FRACTION_BITS;

	logic [smv_pkg::ModeWidth-1:0]      mode_q;
	logic signed [W-1:0]                mem [VECTOR_DEPTH];
	logic [16:0]                        idx_wide;
	logic [AW-1:0]                      addr;
	logic                               in_range;
	logic signed [W-1:0]                in_value;
	logic                               s_accept;
	logic                               advance;
	logic                               stall;
	logic                               emit;

	smv_pkg::smv_ctrl_t                 ctrl_s1;
	smv_pkg::smv_ctrl_t                 ctrl_s3;
	logic signed [W-1:0]                mat_s1;
	logic signed [W-1:0]                rd_s1;
	logic                               in_range_s1;
	logic signed [W-1:0]                vec_s1;
	logic signed [W-1:0]                prod_s3;

	logic signed [W-1:0]                acc_q;
	logic                               open_q;
	logic [smv_pkg::RowIndexWidth-1:0]  row_cnt_q;
	logic signed [W-1:0]                acc_base;
	logic signed [W-1:0]                acc_next;
	logic signed [W-1:0]                row_result;
	logic signed [W-1:0]                out_value_q;
	logic [smv_pkg::RowIndexWidth-1:0]  out_index_q;

	// Unpack the input item
	assign idx_wide = 17'(s_axis_tdata[smv_pkg::IndexWidth-1:0]);
	assign addr     = idx_wide[AW-1:0];
	assign in_range = idx_wide < 17'(VECTOR_DEPTH);
	assign in_value = s_axis_tdata[smv_pkg::IndexWidth +: W];

	// Hold everything only when a row result meets a full output register
	assign emit = ctrl_s3.valid && ((ctrl_s3.op == smv_pkg::OP_NONZERO && ctrl_s3.last) ||
		ctrl_s3.op == smv_pkg::OP_EMPTY);
	assign stall         = emit && m_axis_tvalid && !m_axis_tready;
	assign advance       = !stall;
	assign s_axis_tready = advance;
	assign s_accept      = s_axis_tvalid && advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= smv_pkg::MODE_PLUS_TIMES;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Vector store: write loads at acceptance, registered read for nonzeros
	always_ff @(posedge clk) begin
		if (s_accept && s_axis_tuser == smv_pkg::OP_LOAD && in_range) begin
			mem[addr] <= in_value;
		end
		if (advance) begin
			rd_s1       <= mem[addr];
			in_range_s1 <= in_range;
			mat_s1      <= in_value;
		end
	end

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (advance) begin
			ctrl_s1.valid <= s_axis_tvalid;
			ctrl_s1.op    <= s_axis_tuser;
			ctrl_s1.last  <= s_axis_tlast;
		end
	end

	// Columns beyond the store read zero
	assign vec_s1 = in_range_s1 ? rd_s1 : '0;

	smv_product #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_product (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.mode    (mode_q),
		.ctrl_s1 (ctrl_s1),
		.mat_s1  (mat_s1),
		.vec_s1  (vec_s1),
		.ctrl_s3 (ctrl_s3),
		.prod_s3 (prod_s3)
	);

	// Accumulate; a closed row restarts from the identity
	always_comb begin
		acc_base = open_q ? acc_q : smv_pkg::identity_of(mode_q);
		acc_next = smv_pkg::sr_add(mode_q, acc_base, prod_s3, FixOne);
		row_result = (ctrl_s3.op == smv_pkg::OP_NONZERO) ? acc_next : acc_base;
	end

	// Row state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q        <= 1'b0;
			row_cnt_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (advance && emit) begin
				open_q        <= 1'b0;
				row_cnt_q     <= row_cnt_q + 1'b1;
				m_axis_tvalid <= 1'b1;
			end else begin
				if (advance && ctrl_s3.valid && ctrl_s3.op == smv_pkg::OP_NONZERO) begin
					open_q <= 1'b1;
				end
				if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Accumulator and result payload
	always_ff @(posedge clk) begin
		if (advance && ctrl_s3.valid && ctrl_s3.op == smv_pkg::OP_NONZERO) begin
			acc_q <= acc_next;
		end
		if (advance && emit) begin
			out_value_q <= row_result;
			out_index_q <= row_cnt_q;
		end
	end

	assign m_axis_tdata = {out_index_q, out_value_q};

endmodule

`default_nettype wire

/* src/smv_product.sv */
`timescale 1ns / 1ps
`default_nettype none

module smv_product #(
	parameter int FRACTION_BITS = smv_pkg::FractionBits
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   advance,
	input  wire logic [smv_pkg::ModeWidth-1:0]          mode,
	input  wire smv_pkg::smv_ctrl_t                     ctrl_s1,
	input  wire logic signed [smv_pkg::ValueWidth-1:0]  mat_s1,
	input  wire logic signed [smv_pkg::ValueWidth-1:0]  vec_s1,
	output smv_pkg::smv_ctrl_t                          ctrl_s3,
	output logic signed [smv_pkg::ValueWidth-1:0]       prod_s3
);

	localparam int W  = smv_pkg::ValueWidth;
	localparam int PW = 2 * W;
	localparam logic signed [W-1:0] FixOne = W'(1) << FRACTION_BITS;

	smv_pkg::smv_ctrl_t   ctrl_s2;
	logic signed [PW-1:0] mul_s2;
	logic signed [W-1:0]  alt_s2;
	logic signed [PW-1:0] mul_shift;
	logic signed [W-1:0]  mul_sat;
	logic                 use_mul;

	// Advance control of stages two and three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (advance) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// Stage two: full product, plus the saturated sum or logical and
	always_ff @(posedge clk) begin
		if (advance) begin
			mul_s2 <= PW'(mat_s1) * PW'(vec_s1);
			if (mode == smv_pkg::MODE_OR_AND) begin
				alt_s2 <= (mat_s1 != '0 && vec_s1 != '0) ? FixOne : '0;
			end else begin
				alt_s2 <= smv_pkg::sat_add(mat_s1, vec_s1);
			end
		end
	end

	// Floor shift of the product, then saturate to the value width
	always_comb begin
		mul_shift = mul_s2 >>> FRACTION_BITS;
		if (mul_shift[PW-1:W-1] == '0 || mul_shift[PW-1:W-1] == '1) begin
			mul_sat = mul_shift[W-1:0];
		end else begin
			mul_sat = mul_shift[PW-1] ? smv_pkg::FixMin : smv_pkg::FixMax;
		end
		use_mul = !(mode == smv_pkg::MODE_MIN_PLUS || mode == smv_pkg::MODE_OR_AND ||
			mode == smv_pkg::MODE_MAX_PLUS);
	end

	// Stage three: semiring product
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3 <= use_mul ? mul_sat : alt_s2;
		end
	end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import smv_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int ItemGoal   = 1650;
	localparam int DrainWait  = 6;

	localparam logic [OpWidth-1:0]   OpUnused  = 2'd3;
	localparam logic [ModeWidth-1:0] ModeSpare = 3'd7;

	localparam logic signed [ValueWidth-1:0] FixOne     = 32'sh0001_0000;
	localparam logic signed [ValueWidth-1:0] FixNegOne  = 32'shffff_0000;
	localparam logic signed [ValueWidth-1:0] FixNegHalf = 32'shffff_8000;
	localparam logic signed [ValueWidth-1:0] FixThree   = 32'sh0003_0000;

	typedef struct {
		logic signed [ValueWidth-1:0] value;
		logic [RowIndexWidth-1:0]     row;
	} row_result_t;

	typedef struct {
		bit                           cfg;
		logic [ModeWidth-1:0]         mode;
		logic [OpWidth-1:0]           op;
		logic [IndexWidth-1:0]        idx;
		logic signed [ValueWidth-1:0] val;
		bit                           last;
		bit                           pinned;
		logic signed [ValueWidth-1:0] pin_value;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [47:0]               s_axis_tdata = '0;  // index[9:0], value[41:10]
	logic [OpWidth-1:0]        s_axis_tuser = '0;  // operation[1:0]
	logic                      s_axis_tlast = 1'b0;  // row_last
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [47:0]               m_axis_tdata;  // row_value[31:0], row_index[47:32]
	logic                      cfg_wr_en = 1'b0;
	logic [ModeWidth-1:0]      cfg_wr_data = '0;

	// Predictor state
	logic [ModeWidth-1:0]         sr_mode = MODE_PLUS_TIMES;
	logic signed [ValueWidth-1:0] acc_value = '0;
	bit                           row_open_q = 1'b0;
	logic [RowIndexWidth-1:0]     row_number = '0;
	logic signed [ValueWidth-1:0] x_store [VectorDepth];
	bit                           loaded [VectorDepth];
	int                           loaded_cols [$];

	row_result_t rows_due [$];
	int          items_sent = 0;
	int          rows_taken = 0;
	int          err_count = 0;
	int          send_gap_max = 4;
	int          cycles = 0;

	semiring_sparse_matvec_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("semiring_sparse_matvec_unit: mismatch");
			$finish;
		end
	end

	// Clamp a wide result into Q16.16 range
	function automatic logic signed [ValueWidth-1:0] clamp_fix(input longint v);
		if (v > 64'sd2147483647) return FixMax;
		if (v < -64'sd2147483648) return FixMin;
		return v[ValueWidth-1:0];
	endfunction

	function automatic logic signed [ValueWidth-1:0] mode_zero(input logic [ModeWidth-1:0] m);
		case (m)
			MODE_MIN_PLUS:                 return FixMax;
			MODE_MAX_TIMES, MODE_MAX_PLUS: return FixMin;
			default:                       return '0;
		endcase
	endfunction

	function automatic logic signed [ValueWidth-1:0] semiring_product(
		input logic [ModeWidth-1:0]         m,
		input logic signed [ValueWidth-1:0] a,
		input logic signed [ValueWidth-1:0] b
	);
		longint wide;
		case (m)
			MODE_MIN_PLUS, MODE_MAX_PLUS: return clamp_fix(longint'(a) + longint'(b));
			MODE_OR_AND:                  return (a != 0 && b != 0) ? FixOne : '0;
			default: begin
				// floor of the exact product, then clamp
				wide = longint'(a) * longint'(b);
				return clamp_fix(wide >>> FractionBits);
			end
		endcase
	endfunction

	function automatic logic signed [ValueWidth-1:0] semiring_sum(
		input logic [ModeWidth-1:0]         m,
		input logic signed [ValueWidth-1:0] a,
		input logic signed [ValueWidth-1:0] b
	);
		case (m)
			MODE_MIN_PLUS:                 return (a < b) ? a : b;
			MODE_MAX_TIMES, MODE_MAX_PLUS: return (a > b) ? a : b;
			MODE_OR_AND:                   return (a != 0 || b != 0) ? FixOne : '0;
			default:                       return clamp_fix(longint'(a) + longint'(b));
		endcase
	endfunction

	// Advance the predicted row state by one accepted item
	task automatic apply_item(
		input  logic [OpWidth-1:0]         op,
		input  logic [IndexWidth-1:0]      idx,
		input  logic signed [ValueWidth-1:0] val,
		input  bit                         last,
		output bit                         emits,
		output row_result_t                res
	);
		logic signed [ValueWidth-1:0] base;
		emits = 1'b0;
		res = '{'0, '0};
		case (op)
			OP_LOAD: begin
				x_store[idx] = val;
				if (!loaded[idx]) begin
					loaded[idx] = 1'b1;
					loaded_cols.push_back(int'(idx));
				end
			end
			OP_NONZERO: begin
				base = row_open_q ? acc_value : mode_zero(sr_mode);
				acc_value = semiring_sum(sr_mode, base,
					semiring_product(sr_mode, val, x_store[idx]));
				row_open_q = 1'b1;
				emits = last;
			end
			OP_EMPTY: emits = 1'b1;
			default: ;
		endcase
		if (emits) begin
			res.value = row_open_q ? acc_value : mode_zero(sr_mode);
			res.row = row_number;
			row_number = row_number + 1'b1;
			row_open_q = 1'b0;
			acc_value = mode_zero(sr_mode);
		end
	endtask

	// Offer one item, wait for acceptance, then record what it should produce
	task automatic send_item(
		input logic [OpWidth-1:0]           op,
		input logic [IndexWidth-1:0]        idx,
		input logic signed [ValueWidth-1:0] val,
		input bit                           last,
		input bit                           pinned,
		input logic signed [ValueWidth-1:0] pin_value
	);
		int gap;
		bit emits;
		row_result_t res;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, val, idx};
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		apply_item(op, idx, val, last, emits, res);
		if (emits) begin
			if (pinned) res.value = pin_value;
			rows_due.push_back(res);
		end
		if (op != OpUnused) items_sent++;
	endtask

	// Drop valid and let the pipeline drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic write_mode(input logic [ModeWidth-1:0] m);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sr_mode = m;
	endtask

	// Mix of extremes, small Q16.16 values and raw random words
	function automatic logic signed [ValueWidth-1:0] rand_value();
		logic signed [ValueWidth-1:0] v;
		case ($urandom_range(0, 9))
			0: v = FixMax;
			1: v = FixMin;
			2: v = '0;
			3: v = FixOne;
			4: v = FixNegOne;
			5, 6: v = $urandom;
			default: begin
				v = $urandom_range(0, 8 * 65536);
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	// Result side: random stalls, one long hold-off, check each row
	initial begin : row_sink
		int pause;
		int sink_gap_max;
		row_result_t want;
		logic signed [ValueWidth-1:0] got_value;
		logic [RowIndexWidth-1:0] got_row;
		sink_gap_max = 4;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rows_taken % 50 == 0) sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
			pause = (rows_taken == 120) ? 400 : $urandom_range(0, sink_gap_max);
			if (pause > 0) begin
				m_axis_tready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got_value = m_axis_tdata[31:0];
			got_row = m_axis_tdata[47:32];
			rows_taken++;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row: expected none, actual value %h row %0d",
					$time, got_value, got_row);
				err_count++;
			end else begin
				want = rows_due.pop_front();
				if (got_value !== want.value) begin
					$display("%0t: row_value: expected %h, actual %h", $time, want.value, got_value);
					err_count++;
				end
				if (got_row !== want.row) begin
					$display("%0t: row_index: expected %0d, actual %0d", $time, want.row, got_row);
					err_count++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		int phase;
		int target;
		int pick;
		int n;
		int close;
		logic [IndexWidth-1:0] col;

		plan = '{
			// empty row right after reset gives the plus-times identity
			'{0, MODE_PLUS_TIMES, OP_EMPTY, 10'd0, 32'sd0, 1'b1, 1, 32'sd0},
			'{0, MODE_PLUS_TIMES, OP_LOAD, 10'd0, FixMax, 1'b0, 0, 32'sd0},
			'{0, MODE_PLUS_TIMES, OP_LOAD, 10'd1023, FixMin, 1'b0, 0, 32'sd0},
			'{0, MODE_PLUS_TIMES, OP_LOAD, 10'd5, FixOne, 1'b0, 0, 32'sd0},
			// unused operation does nothing
			'{0, MODE_PLUS_TIMES, OpUnused, 10'd1023, -32'sd1, 1'b1, 0, 32'sd0},
			// saturating multiply and add
			'{0, MODE_PLUS_TIMES, OP_NONZERO, 10'd0, FixMax, 1'b0, 0, 32'sd0},
			'{0, MODE_PLUS_TIMES, OP_NONZERO, 10'd0, FixMax, 1'b1, 1, FixMax},
			'{0, MODE_PLUS_TIMES, OP_NONZERO, 10'd1023, FixMax, 1'b1, 1, FixMin},
			// load inside a row with a stray last, then a marker closes the row
			'{0, MODE_PLUS_TIMES, OP_NONZERO, 10'd5, FixThree, 1'b0, 0, 32'sd0},
			'{0, MODE_PLUS_TIMES, OP_LOAD, 10'd6, FixNegOne, 1'b1, 0, 32'sd0},
			'{0, MODE_PLUS_TIMES, OP_EMPTY, 10'd0, 32'sd0, 1'b0, 1, FixThree},
			'{0, MODE_PLUS_TIMES, OP_NONZERO, 10'd6, FixNegHalf, 1'b1, 0, 32'sd0},
			'{1, MODE_MIN_PLUS, OP_LOAD, 10'd0, 32'sd0, 1'b0, 0, 32'sd0},
			'{0, MODE_MIN_PLUS, OP_EMPTY, 10'd0, 32'sd0, 1'b0, 1, FixMax},
			'{0, MODE_MIN_PLUS, OP_NONZERO, 10'd0, 32'sd1, 1'b1, 1, FixMax},
			'{0, MODE_MIN_PLUS, OP_NONZERO, 10'd1023, FixMin, 1'b0, 0, 32'sd0},
			// switch to or-and with the row still open
			'{1, MODE_OR_AND, OP_LOAD, 10'd0, 32'sd0, 1'b0, 0, 32'sd0},
			'{0, MODE_OR_AND, OP_NONZERO, 10'd5, 32'sd0, 1'b1, 1, FixOne},
			'{1, MODE_MAX_TIMES, OP_LOAD, 10'd0, 32'sd0, 1'b0, 0, 32'sd0},
			'{0, MODE_MAX_TIMES, OP_EMPTY, 10'd0, 32'sd0, 1'b0, 1, FixMin},
			'{0, MODE_MAX_TIMES, OP_NONZERO, 10'd1023, FixMin, 1'b1, 1, FixMax},
			'{1, MODE_MAX_PLUS, OP_LOAD, 10'd0, 32'sd0, 1'b0, 0, 32'sd0},
			'{0, MODE_MAX_PLUS, OP_EMPTY, 10'd0, 32'sd0, 1'b1, 1, FixMin},
			'{0, MODE_MAX_PLUS, OP_NONZERO, 10'd0, FixMax, 1'b0, 0, 32'sd0},
			'{0, MODE_MAX_PLUS, OP_NONZERO, 10'd1023, 32'sd0, 1'b1, 1, FixMax},
			// spare mode code acts as plus-times
			'{1, ModeSpare, OP_LOAD, 10'd0, 32'sd0, 1'b0, 0, 32'sd0},
			'{0, ModeSpare, OP_NONZERO, 10'd5, FixMax, 1'b1, 0, 32'sd0},
			'{1, MODE_OR_AND, OP_LOAD, 10'd0, 32'sd0, 1'b0, 0, 32'sd0},
			'{0, MODE_OR_AND, OP_NONZERO, 10'd6, 32'sd0, 1'b1, 1, 32'sd0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (plan[i]) begin
			if (plan[i].cfg) begin
				write_mode(plan[i].mode);
			end else begin
				send_item(plan[i].op, plan[i].idx, plan[i].val, plan[i].last,
					plan[i].pinned, plan[i].pin_value);
			end
		end

		// Random phases, one mode each; first eight walk every mode code
		phase = 0;
		while (items_sent < ItemGoal) begin
			write_mode(phase < 8 ? ModeWidth'(phase) : ModeWidth'($urandom_range(0, 7)));
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			target = items_sent + $urandom_range(60, 140);
			while (items_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					// burst of loads, stray last allowed
					repeat ($urandom_range(1, 4)) begin
						send_item(OP_LOAD, IndexWidth'($urandom_range(0, 1023)), rand_value(),
							1'($urandom_range(0, 1)), 0, '0);
					end
				end else if (pick < 80) begin
					// one row of nonzeros over loaded columns
					n = $urandom_range(1, 6);
					close = $urandom_range(0, 9);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(0, 19) == 0) begin
							send_item(OP_LOAD, IndexWidth'($urandom_range(0, 1023)),
								rand_value(), 1'b0, 0, '0);
						end
						col = IndexWidth'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
						send_item(OP_NONZERO, col, rand_value(),
							(k == n - 1) && (close > 1), 0, '0);
					end
					if (close == 0) send_item(OP_EMPTY, '0, rand_value(), 1'b0, 0, '0);
				end else if (pick < 90) begin
					send_item(OP_EMPTY, IndexWidth'($urandom_range(0, 1023)), rand_value(),
						1'($urandom_range(0, 1)), 0, '0);
				end else begin
					send_item(OpUnused, IndexWidth'($urandom_range(0, 1023)), rand_value(),
						1'($urandom_range(0, 1)), 0, '0);
				end
			end
			phase++;
		end

		settle();
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("semiring_sparse_matvec_unit: match");
		end else begin
			$display("semiring_sparse_matvec_unit: mismatch");
		end
		$finish;
	end

endmodule
